// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

  // longest accepted line, terminators included
  localparam int unsigned MAX_LINE_CHARS = 512;
  localparam int unsigned LINE_CHARS_W   = 10;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned END_ADDR_W = 17;
  localparam int unsigned REC_NUM_W  = 16;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [END_ADDR_W-1:0] end_addr_t;
  typedef logic [REC_NUM_W-1:0]  rec_num_t;

  typedef enum logic [3:0] {
    KIND_DATA       = 4'd0,
    KIND_RECORD_OK  = 4'd1,
    KIND_CSUM_ERR   = 4'd2,
    KIND_ZERO_COUNT = 4'd3,
    KIND_IGNORED    = 4'd4,
    KIND_BAD_TYPE   = 4'd5,
    KIND_NO_START   = 4'd6,
    KIND_LONG_LINE  = 4'd7,
    KIND_SUMMARY    = 4'd8
  } kind_t;

endpackage

// ===== rtl/ihex_in_if.sv =====
interface ihex_in_if;
  logic               valid;
  logic               ready;
  ihex_pkg::char_t    char_in;
  logic               new_file;
  logic               end_of_data;

  modport source (output valid, output char_in, output new_file, output end_of_data,
                  input ready);
  modport sink   (input valid, input char_in, input new_file, input end_of_data,
                  output ready);
endinterface

// ===== rtl/ihex_out_if.sv =====
interface ihex_out_if;
  logic                valid;
  logic                ready;
  ihex_pkg::kind_t     kind;
  ihex_pkg::addr_t     address;
  logic [7:0]          data;
  ihex_pkg::end_addr_t end_address;
  ihex_pkg::rec_num_t  record_number;

  modport source (output valid, output kind, output address, output data,
                  output end_address, output record_number, input ready);
  modport sink   (input valid, input kind, input address, input data,
                  input end_address, input record_number, output ready);
endinterface

// ===== rtl/intel_hex_record_parser.sv =====
// Intel HEX record parser. Takes one character of HEX text per transfer on
// in_chan and gives at most one result per character on out_chan: each data
// byte with its 16-bit address, a record status at the checksum or type byte,
// warnings for a missing start code, and halts on a zero byte count, a record
// type above 5 or a line longer than MAX_LINE_CHARS (until new_file). An
// end_of_data transfer returns a summary with the address just past the last
// data record. Throughput is one character per clock: all parsing is done in
// the cycle of the input transfer and the result lands in a single output
// register, so in_chan.ready stays high unless that register is full and
// out_chan is stalling. The result of an input transfer is valid in the
// cycle after it.
module intel_hex_record_parser (
  input  logic          clk,
  input  logic          rst_n,
  ihex_in_if.sink       in_chan,
  ihex_out_if.source    out_chan
);

  // character codes
  localparam ihex_pkg::char_t CH_CR    = 8'h0D;
  localparam ihex_pkg::char_t CH_LF    = 8'h0A;
  localparam ihex_pkg::char_t CH_COLON = 8'h3A;
  localparam ihex_pkg::char_t CH_0     = 8'h30;
  localparam ihex_pkg::char_t CH_9     = 8'h39;
  localparam ihex_pkg::char_t CH_LA    = 8'h61;
  localparam ihex_pkg::char_t CH_LF_HX = 8'h66;
  localparam ihex_pkg::char_t CH_UA    = 8'h41;
  localparam ihex_pkg::char_t CH_UF    = 8'h46;

  localparam logic [7:0] TYPE_DATA     = 8'h00;
  localparam logic [7:0] TYPE_EOF      = 8'h01;
  localparam logic [7:0] TYPE_LAST_IGN = 8'h05;

  localparam ihex_pkg::end_addr_t END_LIMIT = ihex_pkg::end_addr_t'(1 << ihex_pkg::ADDR_W);
  localparam ihex_pkg::rec_num_t  REC_MAX   = '1;
  localparam logic [ihex_pkg::LINE_CHARS_W-1:0] LINE_MAX =
    ihex_pkg::LINE_CHARS_W'(ihex_pkg::MAX_LINE_CHARS);

  typedef enum logic [2:0] {
    PH_START,
    PH_COUNT,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_SKIP,
    PH_AFTER_CR
  } phase_t;

  // hex digit decode, anything else reads as zero
  function automatic logic [3:0] nibble_of(input ihex_pkg::char_t c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      n = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF_HX) begin
      n = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      n = 4'(c - CH_UA + 8'd10);
    end
    return n;
  endfunction

  // parser state
  phase_t                               phase_r;
  logic [3:0]                           high_nibble_r;
  logic                                 second_digit_r;
  logic [7:0]                           byte_count_r;
  logic [7:0]                           bytes_left_r;
  ihex_pkg::addr_t                      cur_address_r;
  logic [7:0]                           record_type_r;
  logic [7:0]                           running_sum_r;
  ihex_pkg::end_addr_t                  last_end_r;
  ihex_pkg::rec_num_t                   line_index_r;
  logic [ihex_pkg::LINE_CHARS_W-1:0]    line_chars_r;
  logic                                 halted_r;

  // next state from the character on in_chan
  phase_t                               phase_nxt;
  logic [3:0]                           high_nibble_nxt;
  logic                                 second_digit_nxt;
  logic [7:0]                           byte_count_nxt;
  logic [7:0]                           bytes_left_nxt;
  ihex_pkg::addr_t                      cur_address_nxt;
  logic [7:0]                           record_type_nxt;
  logic [7:0]                           running_sum_nxt;
  ihex_pkg::end_addr_t                  last_end_nxt;
  ihex_pkg::rec_num_t                   line_index_nxt;
  logic [ihex_pkg::LINE_CHARS_W-1:0]    line_chars_nxt;
  logic                                 halted_nxt;

  // result of this character
  logic                                 emit;
  ihex_pkg::kind_t                      res_kind;
  ihex_pkg::addr_t                      res_addr;
  logic [7:0]                           res_data;

  // output register
  logic                                 out_valid_r;
  ihex_pkg::kind_t                      out_kind_r;
  ihex_pkg::addr_t                      out_addr_r;
  logic [7:0]                           out_data_r;
  ihex_pkg::end_addr_t                  out_end_r;
  ihex_pkg::rec_num_t                   out_rec_r;

  logic                                 in_xfer;
  logic                                 term;
  logic                                 done;
  logic [7:0]                           b;
  ihex_pkg::end_addr_t                  end_sum;

  // a new character is taken whenever the output register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    phase_nxt        = phase_r;
    high_nibble_nxt  = high_nibble_r;
    second_digit_nxt = second_digit_r;
    byte_count_nxt   = byte_count_r;
    bytes_left_nxt   = bytes_left_r;
    cur_address_nxt  = cur_address_r;
    record_type_nxt  = record_type_r;
    running_sum_nxt  = running_sum_r;
    last_end_nxt     = last_end_r;
    line_index_nxt   = line_index_r;
    line_chars_nxt   = line_chars_r;
    halted_nxt       = halted_r;

    emit     = 1'b0;
    res_kind = ihex_pkg::KIND_DATA;
    res_addr = '0;
    res_data = '0;
    done     = 1'b0;
    b        = '0;
    end_sum  = '0;
    term     = (in_chan.char_in == CH_CR) || (in_chan.char_in == CH_LF);

    // new_file wipes everything before the character is looked at
    if (in_chan.new_file) begin
      phase_nxt        = PH_START;
      high_nibble_nxt  = '0;
      second_digit_nxt = 1'b0;
      byte_count_nxt   = '0;
      bytes_left_nxt   = '0;
      cur_address_nxt  = '0;
      record_type_nxt  = '0;
      running_sum_nxt  = '0;
      last_end_nxt     = '0;
      line_index_nxt   = '0;
      line_chars_nxt   = '0;
      halted_nxt       = 1'b0;
    end

    if (in_chan.end_of_data) begin
      emit     = 1'b1;
      res_kind = ihex_pkg::KIND_SUMMARY;
    end else if (!halted_nxt) begin
      // lf after cr belongs to the same line, anything else starts a new one
      if (phase_nxt == PH_AFTER_CR) begin
        if (in_chan.char_in == CH_LF) begin
          done = 1'b1;
          if (line_chars_nxt >= LINE_MAX) begin
            halted_nxt = 1'b1;
            emit       = 1'b1;
            res_kind   = ihex_pkg::KIND_LONG_LINE;
          end else begin
            if (line_index_nxt != REC_MAX) line_index_nxt = line_index_nxt + 1'b1;
            line_chars_nxt   = '0;
            second_digit_nxt = 1'b0;
            high_nibble_nxt  = '0;
            phase_nxt        = PH_START;
          end
        end else begin
          if (line_index_nxt != REC_MAX) line_index_nxt = line_index_nxt + 1'b1;
          line_chars_nxt   = '0;
          second_digit_nxt = 1'b0;
          high_nibble_nxt  = '0;
          phase_nxt        = PH_START;
        end
      end

      if (!done) begin
        if (phase_nxt == PH_START) begin
          // blank lines are skipped
          if (!term) begin
            if (line_chars_nxt >= LINE_MAX) begin
              halted_nxt = 1'b1;
              emit       = 1'b1;
              res_kind   = ihex_pkg::KIND_LONG_LINE;
            end else begin
              line_chars_nxt   = line_chars_nxt + 1'b1;
              phase_nxt        = PH_COUNT;
              second_digit_nxt = 1'b0;
              if (in_chan.char_in != CH_COLON) begin
                emit     = 1'b1;
                res_kind = ihex_pkg::KIND_NO_START;
              end
            end
          end
        end else if (line_chars_nxt >= LINE_MAX) begin
          halted_nxt = 1'b1;
          emit       = 1'b1;
          res_kind   = ihex_pkg::KIND_LONG_LINE;
        end else begin
          line_chars_nxt = line_chars_nxt + 1'b1;
          if (term) begin
            if (in_chan.char_in == CH_CR) begin
              phase_nxt = PH_AFTER_CR;
            end else begin
              if (line_index_nxt != REC_MAX) line_index_nxt = line_index_nxt + 1'b1;
              line_chars_nxt   = '0;
              second_digit_nxt = 1'b0;
              high_nibble_nxt  = '0;
              phase_nxt        = PH_START;
            end
          end else if (phase_nxt != PH_SKIP) begin
            if (!second_digit_nxt) begin
              high_nibble_nxt  = nibble_of(in_chan.char_in);
              second_digit_nxt = 1'b1;
            end else begin
              second_digit_nxt = 1'b0;
              b = {high_nibble_nxt, nibble_of(in_chan.char_in)};
              unique case (phase_nxt)
                PH_COUNT: begin
                  byte_count_nxt = b;
                  if (b == 8'd0) begin
                    halted_nxt = 1'b1;
                    emit       = 1'b1;
                    res_kind   = ihex_pkg::KIND_ZERO_COUNT;
                  end else begin
                    running_sum_nxt = b;
                    bytes_left_nxt  = 8'd2;
                    phase_nxt       = PH_ADDR;
                  end
                end
                PH_ADDR: begin
                  cur_address_nxt = {cur_address_nxt[7:0], b};
                  running_sum_nxt = running_sum_nxt + b;
                  bytes_left_nxt  = bytes_left_nxt - 1'b1;
                  if (bytes_left_nxt == 8'd0) phase_nxt = PH_TYPE;
                end
                PH_TYPE: begin
                  record_type_nxt = b;
                  running_sum_nxt = running_sum_nxt + b;
                  if (b == TYPE_DATA) begin
                    end_sum = ihex_pkg::end_addr_t'(cur_address_nxt) +
                              ihex_pkg::end_addr_t'(byte_count_nxt);
                    last_end_nxt   = (end_sum > END_LIMIT) ? END_LIMIT : end_sum;
                    bytes_left_nxt = byte_count_nxt;
                    phase_nxt      = PH_DATA;
                  end else if (b == TYPE_EOF) begin
                    phase_nxt = PH_SKIP;
                    emit      = 1'b1;
                    res_kind  = ihex_pkg::KIND_RECORD_OK;
                    res_data  = b;
                  end else if (b <= TYPE_LAST_IGN) begin
                    phase_nxt = PH_SKIP;
                    emit      = 1'b1;
                    res_kind  = ihex_pkg::KIND_IGNORED;
                    res_data  = b;
                  end else begin
                    halted_nxt = 1'b1;
                    emit       = 1'b1;
                    res_kind   = ihex_pkg::KIND_BAD_TYPE;
                    res_data   = b;
                  end
                end
                PH_DATA: begin
                  emit            = 1'b1;
                  res_kind        = ihex_pkg::KIND_DATA;
                  res_addr        = cur_address_nxt;
                  res_data        = b;
                  running_sum_nxt = running_sum_nxt + b;
                  cur_address_nxt = cur_address_nxt + 1'b1;
                  bytes_left_nxt  = bytes_left_nxt - 1'b1;
                  if (bytes_left_nxt == 8'd0) phase_nxt = PH_CSUM;
                end
                PH_CSUM: begin
                  running_sum_nxt = running_sum_nxt + b;
                  phase_nxt       = PH_SKIP;
                  emit            = 1'b1;
                  res_kind        = (running_sum_nxt == 8'd0) ? ihex_pkg::KIND_RECORD_OK
                                                              : ihex_pkg::KIND_CSUM_ERR;
                  res_data        = record_type_nxt;
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
    end
  end

  // state registers, updated once per character transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      high_nibble_r  <= '0;
      second_digit_r <= 1'b0;
      byte_count_r   <= '0;
      bytes_left_r   <= '0;
      cur_address_r  <= '0;
      record_type_r  <= '0;
      running_sum_r  <= '0;
      last_end_r     <= '0;
      line_index_r   <= '0;
      line_chars_r   <= '0;
      halted_r       <= 1'b0;
    end else if (in_xfer) begin
      phase_r        <= phase_nxt;
      high_nibble_r  <= high_nibble_nxt;
      second_digit_r <= second_digit_nxt;
      byte_count_r   <= byte_count_nxt;
      bytes_left_r   <= bytes_left_nxt;
      cur_address_r  <= cur_address_nxt;
      record_type_r  <= record_type_nxt;
      running_sum_r  <= running_sum_nxt;
      last_end_r     <= last_end_nxt;
      line_index_r   <= line_index_nxt;
      line_chars_r   <= line_chars_nxt;
      halted_r       <= halted_nxt;
    end
  end

  // result register: valid is control, payload loads only with a new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_kind_r <= res_kind;
      out_addr_r <= res_addr;
      out_data_r <= res_data;
      out_end_r  <= last_end_nxt;
      out_rec_r  <= line_index_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_kind_r;
  assign out_chan.address       = out_addr_r;
  assign out_chan.data          = out_data_r;
  assign out_chan.end_address   = out_end_r;
  assign out_chan.record_number = out_rec_r;

  // a halted parser stays silent on plain characters
  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && halted_r && !in_chan.new_file && !in_chan.end_of_data |=> !out_valid_r)
    else $error("result produced while halted");

  // end_of_data always yields a summary in the next cycle
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_chan.end_of_data |=>
      out_valid_r && (out_kind_r == ihex_pkg::KIND_SUMMARY))
    else $error("end_of_data without summary");

  // entering halt always comes with a halting result
  a_halt_reason: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |->
      out_valid_r && ((out_kind_r == ihex_pkg::KIND_ZERO_COUNT) ||
                      (out_kind_r == ihex_pkg::KIND_BAD_TYPE) ||
                      (out_kind_r == ihex_pkg::KIND_LONG_LINE)))
    else $error("halt without halting result");

  // line length counter never passes the limit
  a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
    line_chars_r <= LINE_MAX)
    else $error("line length counter overran");

endmodule
